FILE: sv/assert_macros.svh
// Assertion macros for the RTL; they expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/nkro_pkg.sv
// Package for the NKRO report builder: sizes, word types, codes and the control store.
package nkro_pkg;

	localparam int KEY_MAP_BYTES    = 29;
	localparam int LAST_KEY_CODE    = 221;
	localparam int REPORT_KEY_LIMIT = 29;
	localparam int KB_EFF = (KEY_MAP_BYTES < REPORT_KEY_LIMIT) ? KEY_MAP_BYTES : REPORT_KEY_LIMIT;
	localparam int IDX_W  = (KB_EFF > 1) ? $clog2(KB_EFF) : 1;

	localparam logic [IDX_W-1:0] IDX_END  = IDX_W'(KB_EFF - 1);
	localparam logic [4:0]       MOD_PAGE = 5'b11100; // codes E0..E7

	typedef enum logic [2:0] {
		CMD_PRESS   = 3'd0,
		CMD_RELEASE = 3'd1,
		CMD_REL_ALL = 3'd2,
		CMD_SEND    = 3'd3,
		CMD_QUERY   = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_RANGE     = 3'd1,
		ST_UNCHANGED = 3'd2,
		ST_SENT      = 3'd3,
		ST_REFUSED   = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] key_code;
		logic       host_accepted;
	} cmd_word_t;

	typedef struct packed {
		logic       is_report_byte;
		logic [7:0] report_byte;
		logic [4:0] byte_index;
		logic       end_of_report;
		logic [2:0] status;
		logic       key_now;
		logic       key_before;
		logic       any_modifier_now;
		logic       any_modifier_before;
		logic       last;
	} rpt_word_t;

	// program addresses
	typedef enum logic [3:0] {
		P_IDLE   = 4'd0,
		P_UPD    = 4'd1,
		P_STAT   = 4'd2,
		P_CLR    = 4'd3,
		P_CMPL   = 4'd4,
		P_DEC    = 4'd5,
		P_MOD    = 4'd6,
		P_KEY    = 4'd7,
		P_NEXT   = 4'd8,
		P_COMMIT = 4'd9
	} pc_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_UPDATE,
		OP_STATUS,
		OP_CLEAR,
		OP_CMP,
		OP_DECIDE,
		OP_MOD,
		OP_KEY,
		OP_NEXT,
		OP_COMMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,     // fall through
		C_ALWAYS,   // jump to target
		C_DISPATCH, // wait for a command word, then branch on it
		C_NOT_END,  // jump while the byte index is short of the last key byte
		C_PRE,      // jump while the first of two reports is in progress
		C_SAME      // jump if nothing differs from the last sent report
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
		logic  sel_idx; // key stores addressed by the byte counter, not the code
	} ctrl_t;

	function automatic ctrl_t ucode(pc_t pc);
		ctrl_t w;
		w = '{op: OP_IDLE, cond: C_ALWAYS, target: P_IDLE, sel_idx: 1'b0};
		unique case (pc)
			P_IDLE:   w = '{op: OP_IDLE,   cond: C_DISPATCH, target: P_IDLE,   sel_idx: 1'b0};
			P_UPD:    w = '{op: OP_UPDATE, cond: C_NEXT,     target: P_STAT,   sel_idx: 1'b0};
			P_STAT:   w = '{op: OP_STATUS, cond: C_ALWAYS,   target: P_IDLE,   sel_idx: 1'b0};
			P_CLR:    w = '{op: OP_CLEAR,  cond: C_ALWAYS,   target: P_STAT,   sel_idx: 1'b0};
			P_CMPL:   w = '{op: OP_CMP,    cond: C_NOT_END,  target: P_CMPL,   sel_idx: 1'b1};
			P_DEC:    w = '{op: OP_DECIDE, cond: C_SAME,     target: P_STAT,   sel_idx: 1'b0};
			P_MOD:    w = '{op: OP_MOD,    cond: C_NEXT,     target: P_KEY,    sel_idx: 1'b0};
			P_KEY:    w = '{op: OP_KEY,    cond: C_NOT_END,  target: P_KEY,    sel_idx: 1'b1};
			P_NEXT:   w = '{op: OP_NEXT,   cond: C_PRE,      target: P_MOD,    sel_idx: 1'b0};
			P_COMMIT: w = '{op: OP_COMMIT, cond: C_ALWAYS,   target: P_IDLE,   sel_idx: 1'b0};
			default:  w = '{op: OP_IDLE,   cond: C_ALWAYS,   target: P_IDLE,   sel_idx: 1'b0};
		endcase
		return w;
	endfunction

endpackage

FILE: sv/nkro_key_report_builder.sv
// NKRO key report builder: key bitmap, modifier byte, last-sent copies and report streaming.
//
//   channel | direction | handshake             | word
//   cmd     | in        | cmd_valid / cmd_stall | cmd_word  (command, key_code, host_accepted)
//   rpt     | out       | rpt_valid / rpt_stall | rpt_word  (report bytes and status)
//
// One command at a time; cmd_stall is high whenever the sequencer is away from its idle step.
// Query and unknown commands go straight to the status step; press and release first take an
// update step and release all a clear step. A send makes a compare pass over the key bytes and
// a decide step, then reports its status if unchanged, or else streams one or two reports, each a
// modifier byte, the key bytes and a bubble step, and ends with a commit step.
// rpt_stall holds the sequencer on a word-emitting step only while the output register is full.
// Reset clears both key stores and both modifier bytes at once.
`include "assert_macros.svh"

module nkro_key_report_builder import nkro_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd_word,
	output logic      rpt_valid,
	input  logic      rpt_stall,
	output rpt_word_t rpt_word
);

	pc_t        pc_q;
	logic [7:0] cur_keys_q  [KB_EFF];
	logic [7:0] sent_keys_q [KB_EFF];
	logic [7:0] cur_mods_q;
	logic [7:0] sent_mods_q;
	rpt_word_t  rpt_q;
	logic       rpt_valid_q;

	logic [2:0]       cmd_q;
	logic [7:0]       code_q;
	logic             acc_q;
	logic [IDX_W-1:0] idx_q;
	logic             differ_q;
	logic             pass_q;    // 1 while streaming the final report
	logic             pre_sel_q; // first report: 1 sent keys + current mods, 0 the reverse
	logic             now_q;
	logic             before_q;

	ctrl_t            cw;
	logic             is_key;
	logic             is_mod;
	logic [IDX_W-1:0] code_idx;
	logic [IDX_W-1:0] addr;
	logic [7:0]       cur_byte;
	logic [7:0]       sent_byte;
	logic [7:0]       bit_mask;
	logic             live_now;
	logic             live_before;
	logic             flag_now;
	logic             flag_before;
	logic             send_taken;
	logic [7:0]       mod_diff;
	logic             pre_on;
	logic             pre_off;
	logic             same;
	logic             emit;
	logic             advance;
	logic             accept;
	logic             at_end;
	pc_t              pc_inc;
	pc_t              pc_d;
	pc_t              dispatch_pc;
	rpt_word_t        word_d;

	assign cw       = ucode(pc_q);
	assign is_key   = (code_q <= 8'(LAST_KEY_CODE)) && (code_q[7:3] < 5'(KB_EFF));
	assign is_mod   = !is_key && (code_q[7:3] == MOD_PAGE);
	assign code_idx = code_q[3 +: IDX_W];
	assign addr     = cw.sel_idx ? idx_q : code_idx;
	assign cur_byte  = cur_keys_q[addr];
	assign sent_byte = sent_keys_q[addr];
	assign bit_mask  = 8'b1 << code_q[2:0];

	assign live_now    = is_key ? |(cur_byte & bit_mask)
	                   : is_mod ? |(cur_mods_q & bit_mask) : 1'b0;
	assign live_before = is_key ? |(sent_byte & bit_mask)
	                   : is_mod ? |(sent_mods_q & bit_mask) : 1'b0;
	// key stores are busy with the byte counter while streaming, so use the latched bits
	assign flag_now    = cw.sel_idx ? now_q : live_now;
	assign flag_before = cw.sel_idx ? before_q : live_before;
	// an accepted send leaves the sent copy equal to the current one
	assign send_taken  = (cmd_q == CMD_SEND) && acc_q;

	assign mod_diff = cur_mods_q ^ sent_mods_q;
	assign pre_on   = differ_q && |(mod_diff & cur_mods_q);
	assign pre_off  = differ_q && !pre_on && |(mod_diff & sent_mods_q);
	assign same     = !differ_q && (mod_diff == 8'd0);
	assign at_end   = (idx_q == IDX_END);

	assign emit    = (cw.op == OP_STATUS) || (cw.op == OP_MOD) || (cw.op == OP_KEY);
	assign advance = !emit || !rpt_valid_q || !rpt_stall;
	assign accept  = cmd_valid && !cmd_stall;

	assign cmd_stall = (pc_q != P_IDLE);
	assign rpt_valid = rpt_valid_q;
	assign rpt_word  = rpt_q;

	always_comb begin
		unique case (cmd_word.command)
			CMD_PRESS, CMD_RELEASE: dispatch_pc = P_UPD;
			CMD_REL_ALL:            dispatch_pc = P_CLR;
			CMD_SEND:               dispatch_pc = P_CMPL;
			default:                dispatch_pc = P_STAT;
		endcase
	end

	always_comb begin
		pc_inc = pc_t'(pc_q + 4'd1);
		unique case (cw.cond)
			C_NEXT:     pc_d = pc_inc;
			C_ALWAYS:   pc_d = cw.target;
			C_DISPATCH: pc_d = cmd_valid ? dispatch_pc : P_IDLE;
			C_NOT_END:  pc_d = at_end ? pc_inc : cw.target;
			C_PRE:      pc_d = pass_q ? pc_inc : cw.target;
			C_SAME:     pc_d = same ? cw.target : pc_inc;
			default:    pc_d = P_IDLE;
		endcase
	end

	// result word for the current step
	always_comb begin
		word_d = '0;
		word_d.key_now             = flag_now;
		word_d.key_before          = send_taken ? flag_now : flag_before;
		word_d.any_modifier_now    = |cur_mods_q;
		word_d.any_modifier_before = send_taken ? |cur_mods_q : |sent_mods_q;
		word_d.status              = ST_DONE;
		unique case (cw.op)
			OP_STATUS: begin
				word_d.last = 1'b1;
				if (cmd_q == CMD_SEND) begin
					word_d.status = ST_UNCHANGED;
				end else if ((cmd_q == CMD_PRESS || cmd_q == CMD_RELEASE || cmd_q == CMD_QUERY)
				             && !is_key && !is_mod) begin
					word_d.status = ST_RANGE;
				end
			end
			OP_MOD: begin
				word_d.is_report_byte = 1'b1;
				word_d.report_byte    = (!pass_q && !pre_sel_q) ? sent_mods_q : cur_mods_q;
			end
			OP_KEY: begin
				word_d.is_report_byte = 1'b1;
				word_d.report_byte    = (!pass_q && pre_sel_q) ? sent_byte : cur_byte;
				word_d.byte_index     = 5'(idx_q) + 5'd1;
				word_d.end_of_report  = at_end;
				if (at_end && pass_q) begin
					word_d.last   = 1'b1;
					word_d.status = acc_q ? ST_SENT : ST_REFUSED;
				end
			end
			default: ;
		endcase
	end

	// control state and the key/modifier stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= P_IDLE;
			rpt_valid_q <= 1'b0;
			cur_mods_q  <= '0;
			sent_mods_q <= '0;
			for (int i = 0; i < KB_EFF; i++) begin
				cur_keys_q[i]  <= '0;
				sent_keys_q[i] <= '0;
			end
		end else begin
			if (emit && advance) begin
				rpt_valid_q <= 1'b1;
			end else if (!rpt_stall) begin
				rpt_valid_q <= 1'b0;
			end
			if (advance) begin
				pc_q <= pc_d;
				unique case (cw.op)
					OP_UPDATE: begin
						if (is_key) begin
							if (cmd_q == CMD_PRESS) cur_keys_q[code_idx] <= cur_byte | bit_mask;
							else                    cur_keys_q[code_idx] <= cur_byte & ~bit_mask;
						end else if (is_mod) begin
							if (cmd_q == CMD_PRESS) cur_mods_q <= cur_mods_q | bit_mask;
							else                    cur_mods_q <= cur_mods_q & ~bit_mask;
						end
					end
					OP_CLEAR: begin
						cur_mods_q <= '0;
						for (int i = 0; i < KB_EFF; i++) begin
							cur_keys_q[i] <= '0;
						end
					end
					OP_COMMIT: begin
						if (acc_q) begin
							sent_mods_q <= cur_mods_q;
							for (int i = 0; i < KB_EFF; i++) begin
								sent_keys_q[i] <= cur_keys_q[i];
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (emit && advance) begin
			rpt_q <= word_d;
		end
		if (accept) begin
			cmd_q    <= cmd_word.command;
			code_q   <= cmd_word.key_code;
			acc_q    <= cmd_word.host_accepted;
			idx_q    <= '0;
			differ_q <= 1'b0;
		end else if (advance) begin
			unique case (cw.op)
				OP_CMP: begin
					differ_q <= differ_q | (cur_byte != sent_byte);
					idx_q    <= at_end ? '0 : idx_q + IDX_W'(1);
				end
				OP_DECIDE: begin
					pass_q    <= !(pre_on || pre_off);
					pre_sel_q <= pre_on;
					idx_q     <= '0;
					now_q     <= live_now;
					before_q  <= live_before;
				end
				OP_KEY:  idx_q <= at_end ? '0 : idx_q + IDX_W'(1);
				OP_NEXT: begin
					pass_q <= 1'b1;
					idx_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	`CHK_IMPL(a_idx_range, pc_q != P_IDLE, idx_q <= IDX_END)
	`CHK_NEXT(a_last_ends, emit && advance && word_d.last, pc_q == P_IDLE || pc_q == P_NEXT)
	`CHK_NEXT(a_commit_copy, advance && cw.op == OP_COMMIT && acc_q, sent_mods_q == cur_mods_q)
	`CHK_IMPL(a_eor_index, rpt_valid_q && rpt_q.end_of_report, rpt_q.byte_index == 5'(KB_EFF))

endmodule
